### sv/channel_min_max_average_stats_assert.svh
// Assertion macros shared by the channel statistics RTL.
`ifndef CHANNEL_MIN_MAX_AVERAGE_STATS_ASSERT_SVH
`define CHANNEL_MIN_MAX_AVERAGE_STATS_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define CMMAS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cmmas same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define CMMAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cmmas next-cycle check failed");

`endif

### sv/cmmas_pkg.sv
// Types and constants for the channel statistics block.
package cmmas_pkg;

    localparam int DATA_W = 32;
    localparam int CH_W   = 4;
    localparam int REQ_W  = 3;

    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ACCUM  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_READ   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_SETMIN = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SETMAX = 3'd4;

    // One channel's stored record.
    typedef struct packed {
        logic [DATA_W-1:0] min_value;
        logic [DATA_W-1:0] max_value;
        logic [DATA_W-1:0] spread;
        logic [DATA_W-1:0] midpoint;
        logic [DATA_W-1:0] total;
        logic [DATA_W-1:0] sample_count;
        logic [DATA_W-1:0] mean;
    } t_rec;

endpackage

### sv/cmmas_if.sv
// Request and response channel interfaces for the channel statistics block.
interface cmmas_req_if
    import cmmas_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic [CH_W-1:0]          channel;
    logic signed [DATA_W-1:0] sample;

    modport source (output valid, req_type, channel, sample, input ready);
    modport sink   (input valid, req_type, channel, sample, output ready);
endinterface

interface cmmas_rsp_if
    import cmmas_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] min_value;
    logic signed [DATA_W-1:0] max_value;
    logic signed [DATA_W-1:0] spread;
    logic signed [DATA_W-1:0] midpoint;
    logic signed [DATA_W-1:0] total;
    logic [DATA_W-1:0]        sample_count;
    logic signed [DATA_W-1:0] mean;

    modport source (output valid, min_value, max_value, spread, midpoint, total,
                    sample_count, mean, input ready);
    modport sink   (input valid, min_value, max_value, spread, midpoint, total,
                    sample_count, mean, output ready);
endinterface

### sv/cmmas_ram.sv
// Generic single-port-write, registered-read RAM.
module cmmas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### sv/cmmas_div.sv
// Bit-serial signed-by-unsigned divider, one quotient bit per cycle.
module cmmas_div
    import cmmas_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DATA_W-1:0] i_dividend,
    input  logic [DATA_W-1:0]        i_divisor,
    output logic                     o_done,
    output logic [DATA_W-1:0]        o_quotient
);
    localparam int CNT_W = $clog2(DATA_W);

    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_div;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_neg;
    logic              r_busy;
    logic              r_done;

    logic [DATA_W:0]   w_rem_sh;
    logic [DATA_W:0]   w_diff;
    logic [DATA_W-1:0] w_mag;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    assign w_rem_sh = {r_rem, r_quo[DATA_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_div};
    assign w_mag    = i_dividend[DATA_W-1] ? (DATA_W)'(-i_dividend) : i_dividend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CNT_W'(DATA_W - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end

        if (i_start) begin
            r_quo <= w_mag;
            r_rem <= '0;
            r_div <= i_divisor;
            r_neg <= i_dividend[DATA_W-1];
            r_cnt <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (!w_diff[DATA_W]) begin
                r_rem <= w_diff[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (-r_quo) : r_quo;
endmodule

### sv/channel_min_max_average_stats.sv
// Running min / max / spread / midpoint / sum / count / mean per channel, top level.
//
// Each request beat addresses one channel and returns one response beat with
// that channel's stored record after the request. Clear resets every channel
// at once through per-channel valid bits (a channel not valid reads as zero),
// so no clearing pass follows reset and the block takes a request right away.
// Read, set-min, set-max, clear and unknown codes pass through accept, record
// read from the RAM and write back / response load before the next ready.
// Accumulate adds spread, midpoint and mean steps; the bit-serial divider that
// forms the mean, one quotient bit per cycle, is its longest step. One request
// is in progress at a time, but the response register lets a finished beat wait
// for the sink while the next request is taken; a result only stalls the block
// if the previous one is still unclaimed. A channel index at or above CHANNELS
// returns an all-zero beat and, but for a clear, changes nothing.
module channel_min_max_average_stats
    import cmmas_pkg::*;
#(
    parameter int CHANNELS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cmmas_req_if.sink   i_req,
    cmmas_rsp_if.source o_rsp
);
    `include "channel_min_max_average_stats_assert.svh"

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int REC_W = $bits(t_rec);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SPREAD,
        S_MID,
        S_DIV,
        S_DONE
    } t_state;

    t_state                   r_state;
    logic [REQ_W-1:0]         r_req_type;
    logic [CH_W-1:0]          r_chan;
    logic signed [DATA_W-1:0] r_sample;
    t_rec                     r_rec;
    logic                     r_wr;
    logic [CHANNELS-1:0]      r_valid;
    logic                     r_out_valid;
    t_rec                     r_out;

    t_rec                     n_rec;
    logic                     n_wr;

    logic [IDX_W+CH_W-1:0]    w_in_wide;
    logic [IDX_W+CH_W-1:0]    w_r_wide;
    logic [IDX_W-1:0]         w_in_idx;
    logic [IDX_W-1:0]         w_idx;
    logic                     w_in_range;
    logic                     w_accept;
    logic                     w_slot_free;
    logic                     w_out_load;
    logic                     w_we;
    logic [IDX_W-1:0]         w_raddr;
    logic [REC_W-1:0]         w_rdata;
    t_rec                     w_stored;
    logic signed [DATA_W-1:0] w_sp;
    logic signed [DATA_W-1:0] w_half;
    logic                     w_div_start;
    logic                     w_div_done;
    logic [DATA_W-1:0]        w_quotient;

    // Map the 4-bit channel field onto the RAM index, whatever CHANNELS is.
    assign w_in_wide  = (IDX_W + CH_W)'(i_req.channel);
    assign w_r_wide   = (IDX_W + CH_W)'(r_chan);
    assign w_in_idx   = w_in_wide[IDX_W-1:0];
    assign w_idx      = w_r_wide[IDX_W-1:0];
    assign w_in_range = (32'(r_chan) < 32'(CHANNELS));

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_slot_free = !r_out_valid || o_rsp.ready;
    assign w_out_load  = (r_state == S_DONE) && w_slot_free;
    assign w_we        = w_out_load && r_wr;
    assign w_raddr     = (r_state == S_IDLE) ? w_in_idx : w_idx;

    // Channels untouched since the last clear read as zero.
    assign w_stored = (w_in_range && r_valid[w_idx]) ? t_rec'(w_rdata) : '0;

    // Half the spread, truncated toward zero.
    assign w_sp   = r_rec.spread;
    assign w_half = $signed(w_sp + DATA_W'(w_sp[DATA_W-1])) >>> 1;

    assign w_div_start = (r_state == S_SPREAD);

    // Record after the request, formed from the fetched entry.
    always_comb begin
        n_rec = w_stored;
        n_wr  = 1'b0;
        if ((r_req_type == REQ_CLEAR) || !w_in_range) begin
            n_rec = '0;
        end else begin
            case (r_req_type)
                REQ_ACCUM: begin
                    if (r_sample > $signed(w_stored.max_value)) begin
                        n_rec.max_value = r_sample;
                    end
                    if (r_sample < $signed(w_stored.min_value)) begin
                        n_rec.min_value = r_sample;
                    end
                    n_rec.total = w_stored.total + r_sample;
                    if (w_stored.sample_count != '1) begin
                        n_rec.sample_count = w_stored.sample_count + 1'b1;
                    end
                end
                REQ_SETMIN: begin
                    n_rec.min_value = r_sample;
                    n_wr            = 1'b1;
                end
                REQ_SETMAX: begin
                    n_rec.max_value = r_sample;
                    n_wr            = 1'b1;
                end
                default: begin
                    // Read and unknown codes return the record untouched.
                end
            endcase
        end
    end

    cmmas_ram #(
        .WIDTH (REC_W),
        .DEPTH (CHANNELS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_idx),
        .i_wdata (r_rec),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    cmmas_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_rec.total),
        .i_divisor  (r_rec.sample_count),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_wr        <= 1'b0;
        end else begin
            // Load a finished beat, or drop the response once the sink takes it.
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_req_type <= i_req.req_type;
                        r_chan     <= i_req.channel;
                        r_sample   <= i_req.sample;
                        r_state    <= S_LOAD;
                    end
                end

                S_LOAD: begin
                    // Clear invalidates every channel; answer with channel 0, all zero.
                    if (r_req_type == REQ_CLEAR) begin
                        r_valid <= '0;
                    end
                    r_rec   <= n_rec;
                    r_wr    <= n_wr;
                    r_state <= (w_in_range && (r_req_type == REQ_ACCUM)) ? S_SPREAD : S_DONE;
                end

                S_SPREAD: begin
                    r_rec.spread <= r_rec.max_value - r_rec.min_value;
                    r_state      <= S_MID;
                end

                S_MID: begin
                    r_rec.midpoint <= r_rec.min_value + w_half;
                    r_state        <= S_DIV;
                end

                S_DIV: begin
                    if (w_div_done) begin
                        r_rec.mean <= w_quotient;
                        r_wr       <= 1'b1;
                        r_state    <= S_DONE;
                    end
                end

                S_DONE: begin
                    // Hold until the response register is free, then write back.
                    if (w_slot_free) begin
                        r_out <= r_rec;
                        if (r_wr) begin
                            r_valid[w_idx] <= 1'b1;
                        end
                        r_wr    <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.min_value    = r_out.min_value;
    assign o_rsp.max_value    = r_out.max_value;
    assign o_rsp.spread       = r_out.spread;
    assign o_rsp.midpoint     = r_out.midpoint;
    assign o_rsp.total        = r_out.total;
    assign o_rsp.sample_count = r_out.sample_count;
    assign o_rsp.mean         = r_out.mean;

    // A write-back never overruns an unclaimed response.
    `CMMAS_ASSERT_NOW(a_we_slot, i_clk, i_rst_n, w_we, w_slot_free)
    // The divider finishes only while the sequencer waits for it.
    `CMMAS_ASSERT_NOW(a_div_state, i_clk, i_rst_n, w_div_done, r_state == S_DIV)
    // An accepted beat goes straight to the record fetch.
    `CMMAS_ASSERT_NEXT(a_accept_load, i_clk, i_rst_n, w_accept, r_state == S_LOAD)
    // An accumulate never writes back a zero count.
    `CMMAS_ASSERT_NOW(a_acc_count, i_clk, i_rst_n, w_we && (r_req_type == REQ_ACCUM),
        r_rec.sample_count != '0)
endmodule

### tb/stats_checker.sv
// Predictor and response checker for the channel statistics block.
`timescale 1ns / 100ps

module stats_checker
    import cmmas_pkg::*;
#(
    parameter int CHANNELS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    cmmas_req_if i_req,
    cmmas_rsp_if i_rsp,
    output int   o_errors,
    output int   o_pending
);

    logic [DATA_W-1:0] min_mem    [CHANNELS];
    logic [DATA_W-1:0] max_mem    [CHANNELS];
    logic [DATA_W-1:0] spread_mem [CHANNELS];
    logic [DATA_W-1:0] mid_mem    [CHANNELS];
    logic [DATA_W-1:0] sum_mem    [CHANNELS];
    logic [DATA_W-1:0] count_mem  [CHANNELS];
    logic [DATA_W-1:0] mean_mem   [CHANNELS];

    t_rec expected_records[$];
    int   mismatches = 0;

    function automatic void clear_channels();
        for (int i = 0; i < CHANNELS; i++) begin
            min_mem[i]    = '0;
            max_mem[i]    = '0;
            spread_mem[i] = '0;
            mid_mem[i]    = '0;
            sum_mem[i]    = '0;
            count_mem[i]  = '0;
            mean_mem[i]   = '0;
        end
    endfunction

    function automatic t_rec channel_record(logic [CH_W-1:0] ch);
        return {min_mem[ch], max_mem[ch], spread_mem[ch], mid_mem[ch],
                sum_mem[ch], count_mem[ch], mean_mem[ch]};
    endfunction

    // Apply one request to the shadow stores and return the beat it should produce.
    function automatic t_rec predict_record(logic [REQ_W-1:0] req, logic [CH_W-1:0] ch,
                                            logic [DATA_W-1:0] smp);
        int     half_spread;
        longint sum_wide;
        longint count_wide;
        longint quotient;

        if (req == REQ_CLEAR) begin
            clear_channels();
            return channel_record('0);
        end
        if (ch >= CHANNELS)
            return '0;
        case (req)
            REQ_ACCUM: begin
                if ($signed(smp) > $signed(max_mem[ch]))
                    max_mem[ch] = smp;
                if ($signed(smp) < $signed(min_mem[ch]))
                    min_mem[ch] = smp;
                spread_mem[ch] = max_mem[ch] - min_mem[ch];
                half_spread = $signed(spread_mem[ch]);
                half_spread = half_spread / 2;
                mid_mem[ch] = min_mem[ch] + half_spread;
                sum_mem[ch] = sum_mem[ch] + smp;
                if (count_mem[ch] != '1)
                    count_mem[ch] = count_mem[ch] + 1;
                sum_wide   = $signed(sum_mem[ch]);
                count_wide = {32'd0, count_mem[ch]};
                quotient   = sum_wide / count_wide;
                mean_mem[ch] = quotient[DATA_W-1:0];
            end
            REQ_SETMIN: min_mem[ch] = smp;
            REQ_SETMAX: max_mem[ch] = smp;
            default: ;
        endcase
        return channel_record(ch);
    endfunction

    function automatic int check_field(string name, logic [DATA_W-1:0] want,
                                       logic [DATA_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_rec got;
        t_rec want;

        if (!i_rst_n) begin
            clear_channels();
            expected_records.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                got = {i_rsp.min_value, i_rsp.max_value, i_rsp.spread, i_rsp.midpoint,
                       i_rsp.total, i_rsp.sample_count, i_rsp.mean};
                if (expected_records.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual %h", $time, got);
                    mismatches++;
                end else begin
                    want = expected_records.pop_front();
                    mismatches += check_field("min_value", want.min_value, got.min_value);
                    mismatches += check_field("max_value", want.max_value, got.max_value);
                    mismatches += check_field("spread", want.spread, got.spread);
                    mismatches += check_field("midpoint", want.midpoint, got.midpoint);
                    mismatches += check_field("total", want.total, got.total);
                    mismatches += check_field("sample_count", want.sample_count,
                                              got.sample_count);
                    mismatches += check_field("mean", want.mean, got.mean);
                end
            end
            if (i_req.valid && i_req.ready)
                expected_records.push_back(predict_record(i_req.req_type, i_req.channel,
                                                          i_req.sample));
        end
        o_errors  <= mismatches;
        o_pending <= expected_records.size();
    end

endmodule

### tb/testbench.sv
// Top of the channel statistics testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench
    import cmmas_pkg::*;
;

    localparam int CHANNELS     = 16;
    localparam int RANDOM_ITEMS = 550;
    // Accumulate is the slowest request; even if every request were one, plus
    // stalls, the run stays far below this.
    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 48;
    localparam int IDLE_PCT     = 7;

    // Request codes the block does not define; they must act like a read.
    localparam logic [REQ_W-1:0] REQ_RSVD5 = 3'd5;
    localparam logic [REQ_W-1:0] REQ_RSVD6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSVD7 = 3'd7;

    logic clk = 1'b0;
    logic rst_n;
    bit   calm = 1'b0;     // high: neither side idles
    int   cycles = 0;
    int   errors;
    int   pending;

    cmmas_req_if req_if ();
    cmmas_rsp_if rsp_if ();

    channel_min_max_average_stats #(
        .CHANNELS (CHANNELS)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    stats_checker #(
        .CHANNELS (CHANNELS)
    ) checker_i (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_req     (req_if),
        .i_rsp     (rsp_if),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Hard stop: a hung handshake or a lost beat ends up here.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Response side: stall in about 7 percent of cycles, never while calm.
    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            rsp_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Favor the extremes so wrapping sums, wrapping spreads and sign flips show up.
    function automatic logic [DATA_W-1:0] pick_sample();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return '1;
            4, 5: return $urandom_range(200) - 100;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [REQ_W-1:0] pick_req();
        int unsigned r;

        r = $urandom_range(99);
        if (r < 3)
            return REQ_CLEAR;
        if (r < 58)
            return REQ_ACCUM;
        if (r < 72)
            return REQ_READ;
        if (r < 82)
            return REQ_SETMIN;
        if (r < 92)
            return REQ_SETMAX;
        case ($urandom_range(2))
            0: return REQ_RSVD5;
            1: return REQ_RSVD6;
            default: return REQ_RSVD7;
        endcase
    endfunction

    // Keep half the traffic on a few channels so their statistics build up.
    function automatic logic [CH_W-1:0] pick_channel();
        if ($urandom_range(1))
            return CH_W'($urandom_range(3));
        return CH_W'($urandom_range(CHANNELS - 1));
    endfunction

    // Present one request beat and return at the edge that accepts it.
    task automatic send_request(logic [REQ_W-1:0] req, logic [CH_W-1:0] ch,
                                logic [DATA_W-1:0] smp);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid    <= 1'b1;
        req_if.req_type <= req;
        req_if.channel  <= ch;
        req_if.sample   <= smp;
        do
            @(posedge clk);
        while (!req_if.ready);
    endtask

    initial begin
        rst_n           <= 1'b0;
        req_if.valid    <= 1'b0;
        req_if.req_type <= REQ_READ;
        req_if.channel  <= '0;
        req_if.sample   <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: fresh stores read as zero.
        send_request(REQ_READ, 4'd0, '0);
        // Min and max start from the stored zero, not from the first sample.
        send_request(REQ_ACCUM, 4'd0, 32'd5);
        send_request(REQ_ACCUM, 4'd0, -32'sd7);
        // Full-scale extremes: the spread wraps to minus one.
        send_request(REQ_ACCUM, 4'd0, 32'h7FFF_FFFF);
        send_request(REQ_ACCUM, 4'd0, 32'h8000_0000);
        // Two largest positives: the sum wraps negative, mean follows it.
        send_request(REQ_ACCUM, 4'd1, 32'h7FFF_FFFF);
        send_request(REQ_ACCUM, 4'd1, 32'h7FFF_FFFF);
        send_request(REQ_ACCUM, 4'd15, '1);
        // Overwrite min and max; spread, midpoint and mean stay stale.
        send_request(REQ_SETMIN, 4'd1, 32'h8000_0000);
        send_request(REQ_SETMAX, 4'd1, 32'h8000_0000);
        send_request(REQ_READ, 4'd1, 32'h5555_5555);
        send_request(REQ_ACCUM, 4'd1, 32'd3);
        send_request(REQ_SETMAX, 4'd15, 32'h7FFF_FFFF);
        send_request(REQ_SETMIN, 4'd15, 32'h7FFF_FFFF);
        // Undefined codes change nothing and answer like a read.
        send_request(REQ_RSVD5, 4'd0, '1);
        send_request(REQ_RSVD6, 4'd15, 32'h8000_0000);
        send_request(REQ_RSVD7, 4'd1, 32'h7FFF_FFFF);
        send_request(REQ_READ, 4'd15, '0);
        // Clear answers with channel 0 whatever channel it names.
        send_request(REQ_CLEAR, 4'd9, 32'hAAAA_AAAA);
        send_request(REQ_READ, 4'd1, '0);
        send_request(REQ_ACCUM, 4'd2, -32'sd100);
        send_request(REQ_ACCUM, 4'd2, 32'd100);
        send_request(REQ_CLEAR, 4'd15, '1);

        // Random part, with a stretch in the middle where nobody idles.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            calm = (i >= 200 && i < 320);
            send_request(pick_req(), pick_channel(), pick_sample());
        end
        calm = 1'b0;
        req_if.valid <= 1'b0;

        // Let the last push land, drain, then give stragglers time to show.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && pending == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
